// ===== src/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB package
// Shared widths and types for the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

    localparam int PIX_W      = 8;
    localparam int TDATA_W    = 3 * PIX_W;
    localparam int PIPE_DEPTH = 5;

    // one load enable per pipeline stage, stage 0 first
    typedef logic [PIPE_DEPTH-1:0] pipe_en_t;

endpackage

// ===== src/hsvrgb_datapath.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB datapath
// Five register stages: chroma, ramp, numerator, reciprocal, remainder fix.
// ----------------------------------------------------------------------------
module hsvrgb_datapath
    import hsvrgb_pkg::*;
(
    input  logic             clk,
    input  pipe_en_t         en,
    input  logic [PIX_W-1:0] hue,
    input  logic [PIX_W-1:0] saturation,
    input  logic [PIX_W-1:0] brightness,
    output logic [PIX_W-1:0] red,
    output logic [PIX_W-1:0] green,
    output logic [PIX_W-1:0] blue
);

    localparam logic [2:0] SECT_0 = 3'd0;
    localparam logic [2:0] SECT_1 = 3'd1;
    localparam logic [2:0] SECT_2 = 3'd2;
    localparam logic [2:0] SECT_3 = 3'd3;
    localparam logic [2:0] SECT_4 = 3'd4;
    localparam logic [2:0] SECT_5 = 3'd5;
    localparam logic [2:0] SECT_6 = 3'd6;

    localparam logic [23:0] DIV_C   = 24'd65025;
    localparam logic [16:0] RECIP_C = 17'd66051;   // floor(2^32 / 65025)

    // stage 1
    logic [15:0] c1_reg, c1_next;
    logic [10:0] t1_reg, t1_next;
    logic [7:0]  v1_reg;

    // stage 2
    logic [15:0] m2_reg, m2_next;
    logic [15:0] c2_reg;
    logic [7:0]  k2_reg, k2_next;
    logic [2:0]  sect2_reg, sect2_next;
    logic [7:0]  v2_reg;

    // stage 3
    logic [23:0] n3_reg, n3_next;
    logic [7:0]  lo3_reg, lo3_next;
    logic [2:0]  sect3_reg;
    logic [7:0]  v3_reg;

    // stage 4
    logic [23:0] n4_reg;
    logic [7:0]  q4_reg, q4_next;
    logic [7:0]  lo4_reg;
    logic [2:0]  sect4_reg;
    logic [7:0]  v4_reg;

    // stage 5 (output)
    logic [7:0]  r5_reg, r5_next;
    logic [7:0]  g5_reg, g5_next;
    logic [7:0]  b5_reg, b5_next;

    // stage 2 helpers
    logic [2:0]  raw_sect;
    logic [10:0] tm_base;
    logic [8:0]  tm;
    logic [7:0]  ramp_dist;
    // stage 3 helpers
    logic [23:0] ck_prod;
    logic [23:0] m255;
    logic [15:0] lo_sum;
    // stage 4 helpers
    logic [40:0] recip_prod;
    // stage 5 helpers
    logic [23:0] q_mul;
    logic [23:0] rem;
    logic [7:0]  mid;

    always_comb
    begin
        c1_next = 16'(brightness * saturation);
        t1_next = 11'({hue, 2'b00}) + 11'({hue, 1'b0});
    end

    always_comb
    begin
        raw_sect = 3'(32'(t1_reg >= 11'd255) + 32'(t1_reg >= 11'd510)
                 + 32'(t1_reg >= 11'd765) + 32'(t1_reg >= 11'd1020)
                 + 32'(t1_reg >= 11'd1275) + 32'(t1_reg >= 11'd1530));
        // t mod 510 by removing whole pairs of sectors
        case (raw_sect[2:1])
            2'd0:    tm_base = 11'd0;
            2'd1:    tm_base = 11'd510;
            2'd2:    tm_base = 11'd1020;
            2'd3:    tm_base = 11'd1530;
            default: tm_base = 11'd0;
        endcase
        tm = 9'(t1_reg - tm_base);
        if (tm >= 9'd255)
            ramp_dist = 8'(tm - 9'd255);
        else
            ramp_dist = 8'(9'd255 - tm);
        k2_next    = 8'd255 - ramp_dist;
        // hue 255 lands in sector 6, which wraps to sector 0
        sect2_next = (raw_sect == SECT_6) ? SECT_0 : raw_sect;
        m2_next    = 16'({v1_reg, 8'h00} - 16'(v1_reg)) - c1_reg;
    end

    always_comb
    begin
        ck_prod  = 24'(c2_reg * k2_reg);
        m255     = 24'({m2_reg, 8'h00}) - 24'(m2_reg);
        n3_next  = ck_prod + m255;
        // floor(m / 255), exact for m up to 65025
        lo_sum   = m2_reg + 16'(m2_reg[15:8]) + 16'd1;
        lo3_next = lo_sum[15:8];
    end

    always_comb
    begin
        // estimate is the true quotient or one short
        recip_prod = 41'(n3_reg * RECIP_C);
        q4_next    = recip_prod[39:32];
    end

    always_comb
    begin
        // 65025 = 65536 - 512 + 1
        q_mul = 24'({q4_reg, 16'h0000}) - 24'({q4_reg, 9'h000}) + 24'(q4_reg);
        rem   = n4_reg - q_mul;
        mid   = (rem >= DIV_C) ? q4_reg + 8'd1 : q4_reg;
        case (sect4_reg)
            SECT_0:
            begin
                r5_next = v4_reg;  g5_next = mid;     b5_next = lo4_reg;
            end
            SECT_1:
            begin
                r5_next = mid;     g5_next = v4_reg;  b5_next = lo4_reg;
            end
            SECT_2:
            begin
                r5_next = lo4_reg; g5_next = v4_reg;  b5_next = mid;
            end
            SECT_3:
            begin
                r5_next = lo4_reg; g5_next = mid;     b5_next = v4_reg;
            end
            SECT_4:
            begin
                r5_next = mid;     g5_next = lo4_reg; b5_next = v4_reg;
            end
            SECT_5:
            begin
                r5_next = v4_reg;  g5_next = lo4_reg; b5_next = mid;
            end
            default:
            begin
                r5_next = v4_reg;  g5_next = mid;     b5_next = lo4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            c1_reg <= c1_next;
            t1_reg <= t1_next;
            v1_reg <= brightness;
        end
        if (en[1])
        begin
            m2_reg    <= m2_next;
            c2_reg    <= c1_reg;
            k2_reg    <= k2_next;
            sect2_reg <= sect2_next;
            v2_reg    <= v1_reg;
        end
        if (en[2])
        begin
            n3_reg    <= n3_next;
            lo3_reg   <= lo3_next;
            sect3_reg <= sect2_reg;
            v3_reg    <= v2_reg;
        end
        if (en[3])
        begin
            n4_reg    <= n3_reg;
            q4_reg    <= q4_next;
            lo4_reg   <= lo3_reg;
            sect4_reg <= sect3_reg;
            v4_reg    <= v3_reg;
        end
        if (en[4])
        begin
            r5_reg <= r5_next;
            g5_reg <= g5_next;
            b5_reg <= b5_next;
        end
    end

    assign red   = r5_reg;
    assign green = g5_reg;
    assign blue  = b5_reg;

endmodule

// ===== src/hsv_to_rgb_converter_top.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// 8-bit hue, saturation and brightness in; 8-bit red, green and blue out.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_tvalid / s_tready / s_tdata, results leave on
//   m_tvalid / m_tready / m_tdata, one result per input item, in order.
//   An accepted item passes through all five pipeline stages (chroma
//   product, hue ramp, numerator product, reciprocal product, remainder
//   fix-up and channel select) before m_tvalid rises for it; one item is
//   taken per cycle while a stalled receiver does not hold up the pipeline.
//   Each stage holds a valid bit. A stage loads when it is empty or the
//   stage after it moves on, so bubbles close up while the receiver stalls
//   and s_tready drops only once all five stages are full.
//   Reset clears the valid bits; the pipeline is empty and s_tready is high
//   from the first cycle after reset.
//   Hue 255 is taken as red sector 0.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top
    import hsvrgb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,  // hue, saturation, brightness
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata   // red, green, blue
);

    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic [PIPE_DEPTH-1:0] stage_ready;
    pipe_en_t              en;
    logic [PIX_W-1:0]      red, green, blue;

    assign stage_ready[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || m_tready;

    genvar gi;
    generate
        for (gi = 0; gi < PIPE_DEPTH - 1; gi++)
        begin : g_ready
            assign stage_ready[gi] = !valid_reg[gi] || stage_ready[gi+1];
        end
    endgenerate

    assign en = stage_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
            valid_next[0] = s_tvalid;
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            if (en[i])
                valid_next[i] = valid_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    hsvrgb_datapath u_datapath
    (
        .clk        (clk),
        .en         (en),
        .hue        (s_tdata[PIX_W-1:0]),
        .saturation (s_tdata[2*PIX_W-1:PIX_W]),
        .brightness (s_tdata[3*PIX_W-1:2*PIX_W]),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign s_tready = stage_ready[0];
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_tdata  = {blue, green, red};

    // full pipe with a stalled receiver must push back
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline full and stalled");

    // an empty output stage never blocks the input
    a_empty_out: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[PIPE_DEPTH-1] |-> s_tready)
        else $error("input blocked with empty output stage");

    // output drained and nothing behind it: no result next cycle
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tready && !valid_reg[PIPE_DEPTH-2]) |=> !m_tvalid)
        else $error("result appeared without an item behind it");

endmodule
